// ===== design/pstx_pkg.sv =====
// shared types, constants and helpers of the polar scan to tilted xyz block
package pstx_pkg;

    // angle table depth and default number of rotation stages
    localparam int ATAN_ENTRIES   = 24;
    localparam int DEFAULT_STAGES = 16;

    // datapath widths: rotation x/y in Q16 mm, residual angle in 2^32 units per turn
    localparam int CX_W = 36;
    localparam int CZ_W = 34;

    // rotation gain compensation, unsigned Q0.30
    localparam logic [29:0] GAIN_Q30 = 30'd652032874;

    // fold thresholds of the beam angle, quarter turn
    localparam logic signed [15:0] QUARTER_POS = 16'sd16384;
    localparam logic signed [15:0] QUARTER_NEG = -16'sd16384;

    // queue between front and back
    localparam int QUEUE_AW = 1;

    // configuration register indexes
    localparam logic [1:0] CFG_MOUNT_HEIGHT = 2'd0;
    localparam logic [1:0] CFG_TILT_COS     = 2'd1;
    localparam logic [1:0] CFG_TILT_SIN     = 2'd2;

    // configuration reset values
    localparam logic [15:0]        RST_MOUNT_HEIGHT = 16'd1100;
    localparam logic [15:0]        RST_TILT_COS     = 16'd31507;
    localparam logic signed [16:0] RST_TILT_SIN     = 17'sd9002;

    // arctangent of 2^-i in units of 2^32 per turn
    localparam logic [31:0] ATAN_TAB [0:ATAN_ENTRIES-1] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81
    };

    // classified scan point waiting for the back end
    typedef struct packed {
        logic [15:0]        range_mm;
        logic signed [15:0] angle;
        logic               flip;
        logic [15:0]        intensity;
        logic               last;
    } t_pstx_item;

    // tilt and height settings
    typedef struct packed {
        logic [15:0]        mount_height_mm;
        logic [15:0]        tilt_cos_q15;
        logic signed [16:0] tilt_sin_q15;
    } t_pstx_cfg;

    // saturate to 17 bit signed
    function automatic logic signed [16:0] sat17(input logic signed [35:0] v);
        logic signed [16:0] r;
        if (v > 36'sd65535) begin
            r = 17'sd65535;
        end else if (v < -36'sd65536) begin
            r = -17'sd65536;
        end else begin
            r = v[16:0];
        end
        return r;
    endfunction

    // saturate to 18 bit signed
    function automatic logic signed [17:0] sat18(input logic signed [35:0] v);
        logic signed [17:0] r;
        if (v > 36'sd131071) begin
            r = 18'sd131071;
        end else if (v < -36'sd131072) begin
            r = -18'sd131072;
        end else begin
            r = v[17:0];
        end
        return r;
    endfunction

endpackage

// ===== design/pstx_front.sv =====
// front end: takes scan points and folds the beam angle into the right half plane
module pstx_front import pstx_pkg::*; (
    input  logic               i_start,
    input  logic               i_busy,
    input  logic [15:0]        i_range_mm,
    input  logic signed [15:0] i_beam_angle,
    input  logic [15:0]        i_echo_intensity,
    input  logic               i_scan_last,
    output logic               o_push,
    output t_pstx_item         o_item
);

    // transaction taken whenever the queue has room
    assign o_push = i_start && !i_busy;

    // move angles beyond a quarter turn by half a turn and mark the result for negation
    always_comb begin
        o_item.range_mm  = i_range_mm;
        o_item.intensity = i_echo_intensity;
        o_item.last      = i_scan_last;
        o_item.angle     = i_beam_angle;
        o_item.flip      = 1'b0;
        priority if (i_beam_angle > QUARTER_POS) begin
            o_item.angle = i_beam_angle - 16'sd32767 - 16'sd1;
            o_item.flip  = 1'b1;
        end else if (i_beam_angle < QUARTER_NEG) begin
            o_item.angle = i_beam_angle + 16'sd32767 + 16'sd1;
            o_item.flip  = 1'b1;
        end
    end

endmodule

// ===== design/pstx_queue.sv =====
// short queue of classified points between front and back end
module pstx_queue import pstx_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  t_pstx_item i_item,
    input  logic       i_pop,
    output logic       o_full,
    output logic       o_valid,
    output t_pstx_item o_item
);

    localparam int DEPTH = 2 ** QUEUE_AW;

    t_pstx_item          r_mem [0:DEPTH-1];
    logic [QUEUE_AW-1:0] r_wptr, r_rptr;
    logic [QUEUE_AW:0]   r_count;
    logic                w_do_pop;

    assign w_do_pop = i_pop && (r_count != '0);
    assign o_full   = (r_count == (QUEUE_AW+1)'(DEPTH));
    assign o_valid  = (r_count != '0);
    assign o_item   = r_mem[r_rptr];

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (w_do_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            unique case ({i_push, w_do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_item;
        end
    end

endmodule

// ===== design/pstx_back.sv =====
// back end: pipelined rotation to cartesian form, rounding and tilt about y
module pstx_back import pstx_pkg::*; #(
    parameter int CORDIC_STAGES = DEFAULT_STAGES
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  t_pstx_item         i_item,
    input  t_pstx_cfg          i_cfg,
    output logic               o_done,
    output logic signed [16:0] o_point_x_mm,
    output logic signed [16:0] o_point_y_mm,
    output logic signed [17:0] o_point_z_mm,
    output logic [15:0]        o_point_intensity,
    output logic               o_point_last
);

    localparam int NUM = (CORDIC_STAGES > ATAN_ENTRIES) ? ATAN_ENTRIES : CORDIC_STAGES;

    logic signed [CX_W-1:0] r_cx   [0:NUM];
    logic signed [CX_W-1:0] r_cy   [0:NUM];
    logic signed [CZ_W-1:0] r_cz   [0:NUM];
    logic                   r_vld  [0:NUM];
    logic                   r_flip [0:NUM];
    logic [15:0]            r_int  [0:NUM];
    logic                   r_last [0:NUM];

    logic [45:0] w_prod;

    // start vector: range scaled by the gain constant, in Q16
    assign w_prod = {30'd0, i_item.range_mm} * {16'd0, GAIN_Q30};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else begin
            r_vld[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cx[0]   <= signed'({4'd0, w_prod[45:14]});
        r_cy[0]   <= '0;
        r_cz[0]   <= signed'({{2{i_item.angle[15]}}, i_item.angle, 16'd0});
        r_flip[0] <= i_item.flip;
        r_int[0]  <= i_item.intensity;
        r_last[0] <= i_item.last;
    end

    // one rotation stage for each of the first NUM table entries
    for (genvar g = 0; g < NUM; g++) begin : g_stage
        logic signed [CX_W-1:0] w_dx, w_dy;
        logic signed [CZ_W-1:0] w_at;

        assign w_dx = r_cy[g] >>> g;
        assign w_dy = r_cx[g] >>> g;
        assign w_at = signed'({2'd0, ATAN_TAB[g]});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[g+1] <= 1'b0;
            end else begin
                r_vld[g+1] <= r_vld[g];
            end
        end

        always_ff @(posedge i_clk) begin
            if (!r_cz[g][CZ_W-1]) begin
                r_cx[g+1] <= r_cx[g] - w_dx;
                r_cy[g+1] <= r_cy[g] + w_dy;
                r_cz[g+1] <= r_cz[g] - w_at;
            end else begin
                r_cx[g+1] <= r_cx[g] + w_dx;
                r_cy[g+1] <= r_cy[g] - w_dy;
                r_cz[g+1] <= r_cz[g] + w_at;
            end
            r_flip[g+1] <= r_flip[g];
            r_int[g+1]  <= r_int[g];
            r_last[g+1] <= r_last[g];
        end
    end

    // undo the fold, round to whole mm and saturate
    logic signed [CX_W-1:0] w_xf, w_yf, w_xr, w_yr;
    logic signed [16:0]     r_xx, r_yy;
    logic                   r_rvld, r_rlast;
    logic [15:0]            r_rint;

    assign w_xf = r_flip[NUM] ? -r_cx[NUM] : r_cx[NUM];
    assign w_yf = r_flip[NUM] ? -r_cy[NUM] : r_cy[NUM];
    assign w_xr = (w_xf + 36'sd32768) >>> 16;
    assign w_yr = (w_yf + 36'sd32768) >>> 16;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rvld <= 1'b0;
        end else begin
            r_rvld <= r_vld[NUM];
        end
    end

    always_ff @(posedge i_clk) begin
        r_xx    <= sat17(w_xr);
        r_yy    <= sat17(w_yr);
        r_rint  <= r_int[NUM];
        r_rlast <= r_last[NUM];
    end

    // tilt products
    logic signed [33:0] r_px, r_pz;
    logic signed [16:0] r_my;
    logic               r_mvld, r_mlast;
    logic [15:0]        r_mint;
    logic signed [16:0] w_cos;

    assign w_cos = signed'({1'b0, i_cfg.tilt_cos_q15});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mvld <= 1'b0;
        end else begin
            r_mvld <= r_rvld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_px    <= r_xx * w_cos;
        r_pz    <= r_xx * i_cfg.tilt_sin_q15;
        r_my    <= r_yy;
        r_mint  <= r_rint;
        r_mlast <= r_rlast;
    end

    // add height, round and saturate into the result registers
    logic signed [35:0] w_sx, w_sz, w_h, w_tx, w_tz;

    assign w_sx = signed'({{2{r_px[33]}}, r_px});
    assign w_sz = signed'({{2{r_pz[33]}}, r_pz});
    assign w_h  = signed'({5'd0, i_cfg.mount_height_mm, 15'd0});
    assign w_tx = (w_sx + 36'sd16384) >>> 15;
    assign w_tz = (w_h - w_sz + 36'sd16384) >>> 15;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_done <= 1'b0;
        end else begin
            o_done <= r_mvld;
        end
    end

    always_ff @(posedge i_clk) begin
        o_point_x_mm      <= sat17(w_tx);
        o_point_y_mm      <= r_my;
        o_point_z_mm      <= sat18(w_tz);
        o_point_intensity <= r_mint;
        o_point_last      <= r_mlast;
    end

endmodule

// ===== design/polar_scan_to_tilted_xyz.sv =====
// top level: scan point to tilted xyz converter with settings registers
// A scan point is taken at each rising edge where start is high and busy is low, one per
// clock cycle at most. Its result passes the queue, the start vector register, the rotation
// stages (CORDIC_STAGES, capped at 24), rounding, tilt products and output registers, and
// done then rises; the queue hands a point on in the cycle after it is written. There is
// one result per point, in order, with done high for exactly one cycle. The receiver cannot
// stall and the back end takes a queued point every cycle, so the two-entry queue never fills
// and busy stays low. The throughput is one point per cycle. Settings (mount height, tilt cosine
// and sine in Q1.15) are written over the configuration channel, which is always ready; the
// user must write them only while no point is in flight, and the block does not enforce it.
module polar_scan_to_tilted_xyz import pstx_pkg::*; #(
    parameter int CORDIC_STAGES = DEFAULT_STAGES
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [15:0]        i_range_mm,
    input  logic signed [15:0] i_beam_angle,
    input  logic [15:0]        i_echo_intensity,
    input  logic               i_scan_last,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [16:0]        i_cfg_data,
    output logic               o_done,
    output logic signed [16:0] o_point_x_mm,
    output logic signed [16:0] o_point_y_mm,
    output logic signed [17:0] o_point_z_mm,
    output logic [15:0]        o_point_intensity,
    output logic               o_point_last
);

    t_pstx_cfg  r_cfg;
    t_pstx_item w_front_item, w_queue_item;
    logic       w_push, w_full, w_qvalid;

    assign o_cfg_ready = 1'b1;
    assign busy        = w_full;

    // settings registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mount_height_mm <= RST_MOUNT_HEIGHT;
            r_cfg.tilt_cos_q15    <= RST_TILT_COS;
            r_cfg.tilt_sin_q15    <= RST_TILT_SIN;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_MOUNT_HEIGHT: r_cfg.mount_height_mm <= i_cfg_data[15:0];
                CFG_TILT_COS:     r_cfg.tilt_cos_q15    <= i_cfg_data[15:0];
                CFG_TILT_SIN:     r_cfg.tilt_sin_q15    <= signed'(i_cfg_data);
                default:          r_cfg                 <= r_cfg;
            endcase
        end
    end

    // point intake and angle folding
    pstx_front u_front (
        .i_start          (start),
        .i_busy           (w_full),
        .i_range_mm       (i_range_mm),
        .i_beam_angle     (i_beam_angle),
        .i_echo_intensity (i_echo_intensity),
        .i_scan_last      (i_scan_last),
        .o_push           (w_push),
        .o_item           (w_front_item)
    );

    // decoupling queue
    pstx_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_front_item),
        .i_pop   (w_qvalid),
        .o_full  (w_full),
        .o_valid (w_qvalid),
        .o_item  (w_queue_item)
    );

    // rotation and tilt pipeline
    pstx_back #(
        .CORDIC_STAGES (CORDIC_STAGES)
    ) u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (w_qvalid),
        .i_item            (w_queue_item),
        .i_cfg             (r_cfg),
        .o_done            (o_done),
        .o_point_x_mm      (o_point_x_mm),
        .o_point_y_mm      (o_point_y_mm),
        .o_point_z_mm      (o_point_z_mm),
        .o_point_intensity (o_point_intensity),
        .o_point_last      (o_point_last)
    );

endmodule
